### rtl/hsv2rgb_pkg.sv
// Package: shared types, constants and arithmetic helpers for the HSV to RGB converter
package hsv2rgb_pkg;

  localparam int unsigned PIX_W = 24;

  localparam logic [7:0]  CH_MAX = 8'd255;
  localparam logic [15:0] CH_MAX_SQ = 16'd65025;

  typedef logic [PIX_W-1:0] pixel_t;

  // Hue sector, named after the colour at its start
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  // Stage 1: sector decoded
  typedef struct packed {
    sector_t    sec;
    logic       grey;
    logic [7:0] frac;
    logic [7:0] sat;
    logic [7:0] val;
  } s1_t;

  // Stage 2: saturation products
  typedef struct packed {
    sector_t     sec;
    logic        grey;
    logic [7:0]  val;
    logic [15:0] sf;
    logic [15:0] skf;
    logic [15:0] pprod;
  } s2_t;

  // Stage 3: value products
  typedef struct packed {
    sector_t     sec;
    logic        grey;
    logic [7:0]  val;
    logic [15:0] pprod;
    logic [23:0] qprod;
    logic [23:0] tprod;
  } s3_t;

  // Stage 4: first quotient estimates
  typedef struct packed {
    sector_t     sec;
    logic        grey;
    logic [7:0]  val;
    logic [7:0]  p;
    logic [23:0] qprod;
    logic [23:0] tprod;
    logic [15:0] qest;
    logic [15:0] test;
  } s4_t;

  // Stage 5: corrected quotients by 255
  typedef struct packed {
    sector_t     sec;
    logic        grey;
    logic [7:0]  val;
    logic [7:0]  p;
    logic [15:0] qdiv;
    logic [15:0] tdiv;
  } s5_t;

  // 255 times the sector number
  function automatic logic [10:0] sec_base(sector_t sec);
    logic [10:0] base;
    unique case (sec)
      SEC_RED:     base = 11'd0;
      SEC_YELLOW:  base = 11'd255;
      SEC_GREEN:   base = 11'd510;
      SEC_CYAN:    base = 11'd765;
      SEC_BLUE:    base = 11'd1020;
      SEC_MAGENTA: base = 11'd1275;
      default:     base = 11'd0;
    endcase
    return base;
  endfunction

  // Exact floor(y / 255) for y up to 65025
  function automatic logic [7:0] div255_16(logic [15:0] y);
    logic [16:0] sum;
    sum = 17'(y) + 17'd1 + 17'(y >> 8);
    return sum[15:8];
  endfunction

  // Lower estimate of floor(x / 255), at most one short, x below 255 * 2^16
  function automatic logic [15:0] div255_est(logic [23:0] x);
    logic [24:0] sum;
    sum = 25'(x) + 25'(x >> 8) + 25'(x >> 16);
    return sum[23:8];
  endfunction

  // Correct the estimate by one where the remainder reaches 255
  function automatic logic [15:0] div255_fix(logic [23:0] x, logic [15:0] est);
    logic [24:0] rem;
    rem = 25'(x) - {1'b0, est, 8'd0} + 25'(est);
    return (rem >= 25'(CH_MAX)) ? est + 16'd1 : est;
  endfunction

endpackage

### rtl/hsv2rgb_if.sv
// Interfaces: HSV input stream and RGB result stream with valid/ready
interface hsv2rgb_hsv_if;
  import hsv2rgb_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t hsv_word;
  modport source (output valid, output hsv_word, input ready);
  modport sink   (input valid, input hsv_word, output ready);
endinterface

interface hsv2rgb_rgb_if;
  import hsv2rgb_pkg::*;
  logic   valid;
  logic   ready;
  pixel_t rgb_word;
  modport source (output valid, output rgb_word, input ready);
  modport sink   (input valid, input rgb_word, output ready);
endinterface

### rtl/hsv2rgb_sector.sv
// Stage 1: hue sector and in-sector fraction
module hsv2rgb_sector (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsv2rgb_pkg::pixel_t in_hsv,
  output logic                out_valid,
  input  logic                out_ready,
  output hsv2rgb_pkg::s1_t    out_data
);
  import hsv2rgb_pkg::*;

  logic        valid_r;
  s1_t         data_r;
  s1_t         data_nxt;
  logic [7:0]  hue;
  logic [7:0]  hue_w;
  logic [10:0] six;
  sector_t     sec;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Full-turn hue wraps to zero; sector boundaries are ceil(255k/6)
  always_comb begin
    hue   = in_hsv[23:16];
    hue_w = (hue == CH_MAX) ? 8'd0 : hue;
    six   = {1'b0, hue_w, 2'b00} + {2'b00, hue_w, 1'b0};
    priority if (hue_w >= 8'd213) sec = SEC_MAGENTA;
    else if (hue_w >= 8'd170)     sec = SEC_BLUE;
    else if (hue_w >= 8'd128)     sec = SEC_CYAN;
    else if (hue_w >= 8'd85)      sec = SEC_GREEN;
    else if (hue_w >= 8'd43)      sec = SEC_YELLOW;
    else                          sec = SEC_RED;
    data_nxt.sec  = sec;
    data_nxt.frac = 8'(six - sec_base(sec));
    data_nxt.sat  = in_hsv[15:8];
    data_nxt.val  = in_hsv[7:0];
    data_nxt.grey = (in_hsv[15:8] == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### rtl/hsv2rgb_mul.sv
// Stages 2 and 3: saturation products, then value products
module hsv2rgb_mul (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hsv2rgb_pkg::s1_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hsv2rgb_pkg::s3_t out_data
);
  import hsv2rgb_pkg::*;

  logic  s2_valid_r;
  logic  s3_valid_r;
  logic  s3_ready;
  s2_t   s2_r;
  s2_t   s2_nxt;
  s3_t   s3_r;
  s3_t   s3_nxt;
  logic [15:0] qnum;
  logic [15:0] tnum;

  assign s3_ready  = !s3_valid_r || out_ready;
  assign in_ready  = !s2_valid_r || s3_ready;
  assign out_valid = s3_valid_r;
  assign out_data  = s3_r;

  // s*f, s*(255-f) and v*(255-s)
  always_comb begin
    s2_nxt.sec   = in_data.sec;
    s2_nxt.grey  = in_data.grey;
    s2_nxt.val   = in_data.val;
    s2_nxt.sf    = 16'(in_data.sat) * 16'(in_data.frac);
    s2_nxt.skf   = 16'(in_data.sat) * 16'(CH_MAX - in_data.frac);
    s2_nxt.pprod = 16'(in_data.val) * 16'(CH_MAX - in_data.sat);
  end

  // v*(255^2 - s*f) and v*(255^2 - s*(255-f))
  always_comb begin
    qnum         = CH_MAX_SQ - s2_r.sf;
    tnum         = CH_MAX_SQ - s2_r.skf;
    s3_nxt.sec   = s2_r.sec;
    s3_nxt.grey  = s2_r.grey;
    s3_nxt.val   = s2_r.val;
    s3_nxt.pprod = s2_r.pprod;
    s3_nxt.qprod = 24'(s2_r.val) * 24'(qnum);
    s3_nxt.tprod = 24'(s2_r.val) * 24'(tnum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (in_ready) s2_valid_r <= in_valid;
      if (s3_ready) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s2_r <= s2_nxt;
    if (s3_ready && s2_valid_r) s3_r <= s3_nxt;
  end

endmodule

### rtl/hsv2rgb_div.sv
// Stages 4 to 6: division by 255 twice, then channel routing
module hsv2rgb_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsv2rgb_pkg::s3_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hsv2rgb_pkg::pixel_t out_rgb
);
  import hsv2rgb_pkg::*;

  logic   s4_valid_r;
  logic   s5_valid_r;
  logic   s6_valid_r;
  logic   s5_ready;
  logic   s6_ready;
  s4_t    s4_r;
  s4_t    s4_nxt;
  s5_t    s5_r;
  s5_t    s5_nxt;
  pixel_t rgb_r;
  pixel_t rgb_nxt;
  logic [7:0] q;
  logic [7:0] t;
  logic [7:0] red;
  logic [7:0] grn;
  logic [7:0] blu;

  assign s6_ready  = !s6_valid_r || out_ready;
  assign s5_ready  = !s5_valid_r || s6_ready;
  assign in_ready  = !s4_valid_r || s5_ready;
  assign out_valid = s6_valid_r;
  assign out_rgb   = rgb_r;

  // Quotient estimates; p is finished here
  always_comb begin
    s4_nxt.sec   = in_data.sec;
    s4_nxt.grey  = in_data.grey;
    s4_nxt.val   = in_data.val;
    s4_nxt.p     = div255_16(in_data.pprod);
    s4_nxt.qprod = in_data.qprod;
    s4_nxt.tprod = in_data.tprod;
    s4_nxt.qest  = div255_est(in_data.qprod);
    s4_nxt.test  = div255_est(in_data.tprod);
  end

  // Remainder check fixes the estimates
  always_comb begin
    s5_nxt.sec  = s4_r.sec;
    s5_nxt.grey = s4_r.grey;
    s5_nxt.val  = s4_r.val;
    s5_nxt.p    = s4_r.p;
    s5_nxt.qdiv = div255_fix(s4_r.qprod, s4_r.qest);
    s5_nxt.tdiv = div255_fix(s4_r.tprod, s4_r.test);
  end

  // Second division by 255 and routing by sector; grey pixels take the value on all channels
  always_comb begin
    q = div255_16(s5_r.qdiv);
    t = div255_16(s5_r.tdiv);
    unique case (s5_r.sec)
      SEC_RED:     begin red = s5_r.val; grn = t;        blu = s5_r.p;   end
      SEC_YELLOW:  begin red = q;        grn = s5_r.val; blu = s5_r.p;   end
      SEC_GREEN:   begin red = s5_r.p;   grn = s5_r.val; blu = t;        end
      SEC_CYAN:    begin red = s5_r.p;   grn = q;        blu = s5_r.val; end
      SEC_BLUE:    begin red = t;        grn = s5_r.p;   blu = s5_r.val; end
      default:     begin red = s5_r.val; grn = s5_r.p;   blu = q;        end
    endcase
    if (s5_r.grey) begin
      rgb_nxt = {s5_r.val, s5_r.val, s5_r.val};
    end else begin
      rgb_nxt = {red, grn, blu};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else begin
      if (in_ready) s4_valid_r <= in_valid;
      if (s5_ready) s5_valid_r <= s4_valid_r;
      if (s6_ready) s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s4_r <= s4_nxt;
    if (s5_ready && s4_valid_r) s5_r <= s5_nxt;
    if (s6_ready && s5_valid_r) rgb_r <= rgb_nxt;
  end

endmodule

### rtl/hsv_to_rgb_8bit_core.sv
// Top level: six-stage pipelined HSV to RGB converter, 8 bits per channel
//
// Usage:
//   in_chan carries one packed HSV pixel per transaction: hue in bits 23:16
//   (255 is a full turn and wraps to 0), saturation in 15:8, value in 7:0.
//   out_chan carries the packed RGB pixel: red 23:16, green 15:8, blue 7:0.
//   Both channels use valid/ready; a transaction completes when both are high.
// Timing:
//   The result is registered in the last stage. One pixel per clock is
//   sustained while the receiver keeps taking results. The six register
//   stages are: sector decode, saturation products, value products,
//   quotient estimate, quotient correction, final divide by 255 and
//   channel routing.
// Reset and stall:
//   Synchronous active-low reset clears every stage's valid bit; no pixel is
//   in flight afterwards. Each stage holds its data while the stage after it
//   is full and stalled, so a stalled receiver fills the pipeline stage by
//   stage before in_chan.ready falls; nothing is dropped or repeated.
module hsv_to_rgb_8bit_core (
  input  logic                 clk,
  input  logic                 rst_n,
  hsv2rgb_hsv_if.sink          in_chan,
  hsv2rgb_rgb_if.source        out_chan
);
  import hsv2rgb_pkg::*;

  logic s1_valid;
  logic s1_ready;
  s1_t  s1_data;
  logic s3_valid;
  logic s3_ready;
  s3_t  s3_data;

  // Stage 1
  hsv2rgb_sector u_sector (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_hsv    (in_chan.hsv_word),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  // Stages 2 and 3
  hsv2rgb_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3_data)
  );

  // Stages 4 to 6
  hsv2rgb_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_data   (s3_data),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_rgb   (out_chan.rgb_word)
  );

endmodule

### rtl/hsv2rgb_checker.sv
// Checker: port-level assertions for the HSV to RGB converter, bound to the top level
module hsv2rgb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input hsv2rgb_pkg::pixel_t out_rgb
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rgb))
    else $error("stalled result changed");

  // A free-running receiver never back-pressures the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is drained");

  // An accepted input yields a valid result while the receiver keeps taking results
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready
    ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result missing six cycles after input");

endmodule

bind hsv_to_rgb_8bit_core hsv2rgb_checker u_hsv2rgb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_rgb   (out_chan.rgb_word)
);

### dv/tb_top.sv
// Testbench for the pipelined 8-bit HSV to RGB converter: directed and random pixels
`timescale 1ns / 100ps

module tb_top;
  import hsv2rgb_pkg::*;

  localparam int unsigned FULL_SCALE = 255;
  localparam int unsigned DRAIN_CYCLES = 20;   // pipeline is six deep
  localparam int unsigned RANDOM_PER_PHASE = 450;

  logic clk;
  logic rst_n;

  hsv2rgb_hsv_if in_if ();
  hsv2rgb_rgb_if out_if ();

  hsv_to_rgb_8bit_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // RGB pixels still owed by the converter, oldest first
  pixel_t rgb_expected[$];
  int unsigned error_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  string channel_names[3] = '{"blue", "green", "red"};

  // 2 ns clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Exact integer HSV to RGB conversion, every channel floored
  function automatic pixel_t predict_rgb(pixel_t hsv);
    int unsigned hue, sat, val, six_h, frac, lvl_p, lvl_q, lvl_t;
    sector_t     sec;
    logic [7:0]  red, green, blue;
    hue = 32'(hsv[23:16]);
    sat = 32'(hsv[15:8]);
    val = 32'(hsv[7:0]);
    if (sat == 0) begin
      // no saturation: grey at the value
      red   = 8'(val);
      green = 8'(val);
      blue  = 8'(val);
    end else begin
      // a full turn wraps back to red
      if (hue == FULL_SCALE) hue = 0;
      six_h = 6 * hue;
      sec   = sector_t'(six_h / FULL_SCALE);
      frac  = six_h - FULL_SCALE * (six_h / FULL_SCALE);
      lvl_p = (val * (FULL_SCALE - sat)) / FULL_SCALE;
      lvl_q = (val * (FULL_SCALE * FULL_SCALE - sat * frac)) / (FULL_SCALE * FULL_SCALE);
      lvl_t = (val * (FULL_SCALE * FULL_SCALE - sat * (FULL_SCALE - frac)))
              / (FULL_SCALE * FULL_SCALE);
      case (sec)
        SEC_RED:    {red, green, blue} = {8'(val),   8'(lvl_t), 8'(lvl_p)};
        SEC_YELLOW: {red, green, blue} = {8'(lvl_q), 8'(val),   8'(lvl_p)};
        SEC_GREEN:  {red, green, blue} = {8'(lvl_p), 8'(val),   8'(lvl_t)};
        SEC_CYAN:   {red, green, blue} = {8'(lvl_p), 8'(lvl_q), 8'(val)};
        SEC_BLUE:   {red, green, blue} = {8'(lvl_t), 8'(lvl_p), 8'(val)};
        default:    {red, green, blue} = {8'(val),   8'(lvl_p), 8'(lvl_q)};
      endcase
    end
    return {red, green, blue};
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: mismatch on %s: got %06h, want %06h", $realtime, what, got, want);
    error_count++;
  endtask

  // Drive one HSV pixel and hold it until the transaction completes
  task automatic send_hsv(pixel_t hsv);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.hsv_word <= hsv;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    rgb_expected.push_back(predict_rgb(hsv));
  endtask

  // Sender goes quiet until every owed pixel has come back
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    while (rgb_expected.size() != 0) @(posedge clk);
  endtask

  // Random receiver stalls and result checking
  always @(posedge clk) begin : rgb_monitor
    pixel_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (rgb_expected.size() == 0) begin
        report_mismatch("unexpected pixel", 32'(out_if.rgb_word), 0);
      end else begin
        want = rgb_expected.pop_front();
        for (int ch = 0; ch < 3; ch++)
          if (out_if.rgb_word[ch*8 +: 8] !== want[ch*8 +: 8])
            report_mismatch(channel_names[ch], 32'(out_if.rgb_word), 32'(want));
      end
    end
    out_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Grey: zero saturation at various values and hues, including the wrap hue
  task automatic test_grey_levels();
    send_hsv(24'h000000);
    send_hsv(24'h8000FF);
    send_hsv(24'hFF00AB);
    send_hsv(24'h2A0001);
  endtask

  // Hue at each sector boundary, either side of the 43, 128 and 213 ones, plus the full-turn wrap
  task automatic test_hue_sectors();
    byte unsigned hues[11] = '{0, 42, 43, 85, 127, 128, 170, 212, 213, 254, 255};
    foreach (hues[i]) send_hsv({hues[i], 8'hFF, 8'hFF});
    send_hsv({8'd255, 8'h80, 8'hC0});
    send_hsv({8'd254, 8'h80, 8'hC0});
  endtask

  // Saturation and value at their extremes
  task automatic test_channel_extremes();
    send_hsv(24'hFFFFFF);
    send_hsv(24'h55FF00);
    send_hsv(24'hAA0101);
    send_hsv(24'h1501FF);
    send_hsv(24'hC7FF01);
    send_hsv(24'h6A017F);
    send_hsv(24'h000000);
  endtask

  // Random pixels, biased towards grey, the wrap hue and channel extremes
  task automatic test_random_stream(int unsigned count, int unsigned snd_pct,
                                    int unsigned rcv_pct);
    logic [7:0] hue, sat, val;
    sender_idle_pct   = snd_pct;
    receiver_idle_pct = rcv_pct;
    repeat (count) begin
      hue = 8'($urandom_range(255));
      sat = 8'($urandom_range(255));
      val = 8'($urandom_range(255));
      case ($urandom_range(15))
        0: sat = 8'h00;
        1: hue = 8'hFF;
        2: sat = 8'hFF;
        3: val = 8'hFF;
        4: val = 8'h00;
        default: ;
      endcase
      send_hsv({hue, sat, val});
    end
    wait_results_drained();
  endtask

  // Stimulus sequence
  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.hsv_word = '0;
    out_if.ready   = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct   = 32;
    receiver_idle_pct = 57;
    test_grey_levels();
    test_hue_sectors();
    test_channel_extremes();
    wait_results_drained();

    test_random_stream(RANDOM_PER_PHASE, 32, 57);
    test_random_stream(RANDOM_PER_PHASE, 57, 32);
    test_random_stream(RANDOM_PER_PHASE, 0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && rgb_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
